@@ sv/text_to_unsigned_radix_parser_core_defines.svh @@
// assertion macros for the radix text parser core
// no dependencies; included by the top level only
`ifndef TEXT_TO_UNSIGNED_RADIX_PARSER_CORE_DEFINES_SVH
`define TEXT_TO_UNSIGNED_RADIX_PARSER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TTURP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TTURP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tturp_pkg.sv @@
// types, codes and helpers for the radix text parser core
// no dependencies; imported by text_to_unsigned_radix_parser_core
`timescale 1ns / 1ps
`default_nettype none

package tturp_pkg;

    localparam int VALUE_W  = 32;
    localparam int RADIX_W  = 5;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;
    localparam int DIGIT_W  = 4;
    localparam int PROD_W   = VALUE_W + RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [PADDR_W-1:0] ADDR_RADIX = 2'd0;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_DIGIT = 3'b010,
        PH_TRAIL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has_char;
        logic              last;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } digit_t;

    // hex digit decode, ok is low for anything that is not 0-9, A-F, a-f
    function automatic digit_t decode_digit(input logic [CHAR_W-1:0] ch);
        digit_t d;
        logic [CHAR_W-1:0] diff;
        d    = '{ok: 1'b0, val: '0};
        diff = '0;
        unique if (ch >= CHAR_0 && ch <= CHAR_9) begin
            diff = ch - CHAR_0;
            d    = '{ok: 1'b1, val: diff[DIGIT_W-1:0]};
        end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
            diff = ch - CHAR_UA + 8'd10;
            d    = '{ok: 1'b1, val: diff[DIGIT_W-1:0]};
        end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
            diff = ch - CHAR_LA + 8'd10;
            d    = '{ok: 1'b1, val: diff[DIGIT_W-1:0]};
        end else begin
            d    = '{ok: 1'b0, val: '0};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ sv/text_to_unsigned_radix_parser_core.sv @@
// radix text parser core: one character per word in, one value and status per string out
// depends on tturp_pkg and text_to_unsigned_radix_parser_core_defines.svh
//
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+------------------------------------
// s_       | in  | s_valid / s_ready | in_word_t  {ch, has_char, last}
// m_       | out | m_valid / m_ready | out_word_t {value, status}
// apb      | in  | psel/penable      | radix at byte address 0
//
// one word per cycle sustained, apart from the last-word stall below; a word is held in the input register
// and a last word's result is then registered in the output register
// the critical path is the 32x5 multiply by the base plus the digit add and overflow test
// aresetn (synchronous) clears valids, phase, accumulator, error and radix (to 10)
// a last word waits in the input register only while the output register holds
// an untaken result; other words never stall
`timescale 1ns / 1ps
`default_nettype none
`include "text_to_unsigned_radix_parser_core_defines.svh"

module text_to_unsigned_radix_parser_core
    import tturp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire in_word_t            s_data,

    output      logic                m_valid,
    input  wire logic                m_ready,
    output      out_word_t           m_data,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output      logic [PDATA_W-1:0]  prdata,
    output      logic                pready
);

    logic [RADIX_W-1:0]  radix_reg;
    logic                in_valid_reg;
    in_word_t            in_word_reg;
    phase_t              phase_reg, phase_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                out_valid_reg;
    out_word_t           out_word_reg, out_word_next;

    logic                advance;
    logic                radix_ok;
    logic                is_space;
    digit_t              dig;
    logic                dig_ok;
    logic [PROD_W-1:0]   prod;
    logic [STATUS_W-1:0] final_status;

    // config port
    assign pready = 1'b1;
    assign prdata = {{(PDATA_W-RADIX_W){1'b0}}, radix_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_RADIX) begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    // handshakes
    assign advance = in_valid_reg && (!in_word_reg.last || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    // per-character update
    assign radix_ok = radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX;
    assign is_space = in_word_reg.ch == SPACE_CODE;
    assign dig      = decode_digit(in_word_reg.ch);
    assign dig_ok   = dig.ok && {1'b0, dig.val} < radix_reg;
    assign prod     = PROD_W'(acc_reg) * PROD_W'(radix_reg) + PROD_W'(dig.val);

    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        final_status  = ST_OK;
        out_word_next = '{value: '0, status: ST_OK};

        if (in_word_reg.has_char && err_reg == ST_OK) begin
            if (!radix_ok) begin
                err_next = ST_INVAL;
            end else begin
                unique case (phase_reg)
                    PH_LEAD, PH_DIGIT: begin
                        if (is_space) begin
                            phase_next = (phase_reg == PH_LEAD) ? PH_LEAD : PH_TRAIL;
                        end else begin
                            phase_next = PH_DIGIT;
                            if (!dig_ok) begin
                                err_next = ST_INVAL;
                            end else if (prod[PROD_W-1:VALUE_W] != '0) begin
                                err_next = ST_OVF;
                            end else begin
                                acc_next = prod[VALUE_W-1:0];
                            end
                        end
                    end
                    PH_TRAIL: begin
                        if (!is_space) begin
                            err_next = ST_INVAL;
                        end
                    end
                    default: begin
                        err_next = ST_INVAL;
                    end
                endcase
            end
        end

        // end of string
        if (in_word_reg.last) begin
            final_status = (err_next == ST_OK && !radix_ok) ? ST_INVAL : err_next;
            out_word_next.status = final_status;
            out_word_next.value  = (final_status == ST_OK) ? acc_next : '0;
            phase_next = PH_LEAD;
            acc_next   = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            err_reg   <= ST_OK;
        end else if (advance) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_word_reg.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_word_reg.last) begin
            out_word_reg <= out_word_next;
        end
    end

    // checks
    `TTURP_ASSERT_NOW(a_err_value_zero, aclk, aresetn,
        out_valid_reg && out_word_reg.status != ST_OK, out_word_reg.value == '0,
        "result with error status carries a nonzero value")
    `TTURP_ASSERT_NOW(a_status_code, aclk, aresetn,
        out_valid_reg, out_word_reg.status <= ST_OVF, "undefined status code")
    `TTURP_ASSERT_NEXT(a_last_gives_result, aclk, aresetn,
        advance && in_word_reg.last, out_valid_reg,
        "string end did not produce a result")
    `TTURP_ASSERT_NEXT(a_last_clears_state, aclk, aresetn,
        advance && in_word_reg.last,
        phase_reg == PH_LEAD && acc_reg == '0 && err_reg == ST_OK,
        "parser state not cleared after string end")

endmodule

`default_nettype wire

@@ tb/sv/radix_parse_checker.sv @@
// checker for the radix text parser core: tracks the base register, predicts
// each string's value and status, and compares every result word in order
// depends on tturp_pkg
`timescale 1ns / 1ps

module radix_parse_checker
    import tturp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    input  logic                s_ready,
    input  in_word_t            s_data,

    input  logic                m_valid,
    input  logic                m_ready,
    input  out_word_t           m_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,

    output int                  fail_count,
    output int                  pending_results,
    output int                  results_checked
);

    logic [RADIX_W-1:0]  base_q;
    phase_t              phase_q;
    logic [VALUE_W-1:0]  acc_q;
    logic [STATUS_W-1:0] err_q;
    out_word_t           expected_q[$];
    int                  mismatches = 0;
    int                  checked = 0;

    function automatic bit base_valid(input logic [RADIX_W-1:0] b);
        return b >= RADIX_MIN && b <= RADIX_MAX;
    endfunction

    // digit value below the base, or -1
    function automatic int char_digit(input logic [CHAR_W-1:0] c, input logic [RADIX_W-1:0] b);
        int v;
        v = -1;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = int'(c) - int'(CHAR_0);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v = int'(c) - int'(CHAR_UA) + 10;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            v = int'(c) - int'(CHAR_LA) + 10;
        end
        if (v >= int'(b)) begin
            v = -1;
        end
        return v;
    endfunction

    task automatic accumulate(input logic [CHAR_W-1:0] c);
        int          d;
        logic [63:0] next;
        d = char_digit(c, base_q);
        if (d < 0) begin
            err_q = ST_INVAL;
        end else begin
            next = 64'(acc_q) * 64'(base_q) + 64'(d);
            if (next > 64'hFFFF_FFFF) begin
                err_q = ST_OVF;
            end else begin
                acc_q = next[VALUE_W-1:0];
            end
        end
    endtask

    task automatic consume_char(input logic [CHAR_W-1:0] c);
        if (err_q == ST_OK) begin
            if (!base_valid(base_q)) begin
                err_q = ST_INVAL;
            end else begin
                case (phase_q)
                    PH_LEAD: begin
                        if (c != SPACE_CODE) begin
                            phase_q = PH_DIGIT;
                            accumulate(c);
                        end
                    end
                    PH_DIGIT: begin
                        if (c == SPACE_CODE) begin
                            phase_q = PH_TRAIL;
                        end else begin
                            accumulate(c);
                        end
                    end
                    default: begin
                        if (c != SPACE_CODE) begin
                            err_q = ST_INVAL;
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic close_string();
        out_word_t r;
        r.status = err_q;
        if (r.status == ST_OK && !base_valid(base_q)) begin
            r.status = ST_INVAL;
        end
        r.value = (r.status == ST_OK) ? acc_q : '0;
        expected_q.push_back(r);
        phase_q = PH_LEAD;
        acc_q   = '0;
        err_q   = ST_OK;
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            base_q  = RADIX_RESET;
            phase_q = PH_LEAD;
            acc_q   = '0;
            err_q   = ST_OK;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RADIX) begin
                base_q = pwdata[RADIX_W-1:0];
            end
            if (s_valid && s_ready) begin
                if (s_data.has_char) begin
                    consume_char(s_data.ch);
                end
                if (s_data.last) begin
                    close_string();
                end
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: value %0h status %0d",
                           m_data.value, m_data.status);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (m_data.value !== want.value) begin
                        $error("value: expected %0h, got %0h", want.value, m_data.value);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        mismatches++;
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= expected_q.size();
        results_checked <= checked;
    end

endmodule

@@ tb/sv/tb.sv @@
// top of the radix text parser testbench: clock, reset, string stimulus,
// base register writes and result back-pressure; verdict from the checker
// depends on tturp_pkg, text_to_unsigned_radix_parser_core and radix_parse_checker
`timescale 1ns / 1ps

module tb;
    import tturp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int PLAN_LEN      = 11;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_word_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_word_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int fail_count;
    int pending_results;
    int results_checked;
    int cycle_count   = 0;
    int chars_sent    = 0;
    int strings_sent  = 0;
    int settings_used = 0;
    bit no_idle       = 1'b0;
    bit hold_req      = 1'b0;

    text_to_unsigned_radix_parser_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    radix_parse_checker i_parse_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_word(input logic [CHAR_W-1:0] c, input logic has_c, input logic lst);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{ch: c, has_char: has_c, last: lst};
        do @(posedge aclk); while (!s_ready);
        if (has_c) begin
            chars_sent++;
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_word(txt[i], 1'b1, i == txt.len() - 1);
        end
        strings_sent++;
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_base(input int b);
        wait_drained();
        apb_write(ADDR_RADIX, PDATA_W'(b));
        settings_used++;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input int d);
        if (d < 10) begin
            return CHAR_0 + CHAR_W'(d);
        end
        return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + CHAR_W'(d - 10);
    endfunction

    // digits in 0xFFFFFFFF for this base, 8 for a base outside 2 to 16
    function automatic int max_digits(input logic [RADIX_W-1:0] b);
        longint unsigned v;
        int              n;
        if (b < RADIX_MIN || b > RADIX_MAX) begin
            return 8;
        end
        v = 64'hFFFF_FFFF;
        n = 0;
        while (v != 0) begin
            v = v / b;
            n++;
        end
        return n;
    endfunction

    task automatic send_random_string(input logic [RADIX_W-1:0] b);
        in_word_t words[$];
        in_word_t sp;
        int       kind;
        int       top_d;
        int       md;
        int       ndig;
        sp    = '{ch: SPACE_CODE, has_char: 1'b1, last: 1'b0};
        top_d = (b >= RADIX_MIN && b <= RADIX_MAX) ? int'(b) : 16;
        md    = max_digits(b);
        kind  = $urandom_range(0, 9);
        if (kind <= 6 || kind == 8) begin
            repeat ($urandom_range(0, 2)) words.push_back(sp);
            if ($urandom_range(0, 3) == 0) begin
                ndig = $urandom_range(md > 1 ? md - 1 : 1, md + 1);
            end else begin
                ndig = $urandom_range(1, md < 4 ? md : 4);
            end
            repeat (ndig) begin
                words.push_back('{ch: digit_char($urandom_range(0, top_d - 1)),
                                  has_char: 1'b1, last: 1'b0});
                if ($urandom_range(0, 9) == 0) begin
                    words.push_back('{ch: CHAR_W'($urandom_range(0, 255)),
                                      has_char: 1'b0, last: 1'b0});
                end
            end
            repeat ($urandom_range(0, 2)) words.push_back(sp);
            if (kind == 8) begin
                if ($urandom_range(0, 1)) begin
                    words[$urandom_range(0, words.size() - 1)].ch = CHAR_W'($urandom_range(0, 255));
                end else begin
                    words.push_back(sp);
                    words.push_back('{ch: digit_char($urandom_range(0, 15)),
                                      has_char: 1'b1, last: 1'b0});
                end
            end
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 6)) begin
                words.push_back('{ch: CHAR_W'($urandom_range(0, 255)),
                                  has_char: $urandom_range(0, 3) != 0, last: 1'b0});
            end
        end else begin
            repeat ($urandom_range(0, 3)) words.push_back(sp);
        end
        if (words.size() == 0 || $urandom_range(0, 3) == 0) begin
            words.push_back('{ch: CHAR_W'($urandom_range(0, 255)), has_char: 1'b0, last: 1'b1});
        end else begin
            words[words.size() - 1].last = 1'b1;
        end
        foreach (words[i]) begin
            send_word(words[i].ch, words[i].has_char, words[i].last);
        end
        strings_sent++;
    endtask

    // result side: random wait per word, one long hold on request
    initial begin
        int gap;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int base_plan[PLAN_LEN];
        int char_plan[PLAN_LEN];
        int start;
        base_plan = '{2, 16, 10, 7, 0, 31, 1, 17, 3, 10, 16};
        char_plan = '{140, 140, 140, 100, 40, 40, 30, 30, 100, 140, 140};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        // base 10 after reset
        send_word(8'h00, 1'b0, 1'b1);
        strings_sent++;
        send_text(" 7 ");
        send_text("  ");
        send_text("1 2");
        send_word(8'hFF, 1'b1, 1'b1);
        strings_sent++;
        send_word("5", 1'b1, 1'b0);
        send_word("x", 1'b0, 1'b0);
        send_word("9", 1'b1, 1'b0);
        send_word("q", 1'b0, 1'b1);
        strings_sent++;
        send_text("A");

        set_base(16);
        send_text("fF");
        send_text("FFFFFFFF");

        for (int p = 0; p < PLAN_LEN; p++) begin
            set_base(base_plan[p]);
            no_idle = (p == 9);
            if (p == 2) begin
                hold_req = 1'b1;
            end
            start = chars_sent;
            while (chars_sent - start < char_plan[p]) begin
                send_random_string(RADIX_W'(base_plan[p]));
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("%0d characters in %0d strings over %0d base settings, %0d results checked",
                 chars_sent, strings_sent, settings_used, results_checked);
        if (pending_results != 0) begin
            $error("%0d expected results never arrived", pending_results);
        end
        if (fail_count == 0 && pending_results == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
